/* design/ins_pkg.sv */
`default_nettype none

package ins_pkg;

  localparam int SLOT_COUNT = 256;
  localparam int SLOT_W     = 8;
  localparam int NODE_W     = 8;
  localparam int SIZE_W     = 9;
  localparam int KIND_W     = 2;

  localparam logic [KIND_W-1:0] KIND_ADD    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REPOS  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_READ   = 2'd3;

  typedef struct packed {
    logic              rd_en;
    logic [SLOT_W-1:0] list_raddr;
    logic [NODE_W-1:0] slot_raddr;
    logic              list_we;
    logic [SLOT_W-1:0] list_waddr;
    logic [NODE_W-1:0] list_wdata;
    logic              slot_we;
    logic [NODE_W-1:0] slot_waddr;
    logic [SLOT_W-1:0] slot_wdata;
  } store_req_t;

endpackage

`default_nettype wire

/* design/ins_store.sv */
`default_nettype none

// Dense member list and slot-of-node table, one write and one read port each.
// Read data is registered and only changes when a read is issued, so it stays
// available for as many cycles as the controller needs it.
module ins_store (
  input  wire logic                        clk,
  input  wire ins_pkg::store_req_t         req,
  output logic [ins_pkg::NODE_W-1:0]       list_rdata,
  output logic [ins_pkg::SLOT_W-1:0]       slot_rdata
);

  logic [ins_pkg::NODE_W-1:0] list_mem [ins_pkg::SLOT_COUNT];
  logic [ins_pkg::SLOT_W-1:0] slot_mem [ins_pkg::SLOT_COUNT];

  always_ff @(posedge clk) begin
    if (req.list_we) begin
      list_mem[req.list_waddr] <= req.list_wdata;
    end
    if (req.rd_en) begin
      list_rdata <= list_mem[req.list_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (req.slot_we) begin
      slot_mem[req.slot_waddr] <= req.slot_wdata;
    end
    if (req.rd_en) begin
      slot_rdata <= slot_mem[req.slot_raddr];
    end
  end

endmodule

`default_nettype wire

/* design/indexed_node_set_unit.sv */
`default_nettype none

// Channel   Direction  Payload
// s_axis    in         tdata: node[7:0], position[15:8]; tuser: kind[1:0]
// m_axis    out        tdata: node_at_position[7:0], set_size[16:8]; tuser: ok[0]
// cfg       in         data: capacity_limit[8:0]
//
// An item is taken in the idle state; the member list and slot table are read
// at that edge; the decide state then decides, writes back and loads the result.
// A reposition that succeeds adds a swap state after the decide state, since it
// writes each memory twice through a single write port.
// The result register frees the input side: a new item is taken while a result
// waits. The decide cycle holds only while the result register is still full.
// Synchronous reset clears the membership bits and size; capacity goes to 256.
module indexed_node_set_unit #(
  parameter int NODE_COUNT = 256
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,   // node[7:0], position[15:8]
  input  wire logic [1:0]  s_axis_tuser,   // kind[1:0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,   // node_at_position[7:0], set_size[16:8]
  output logic [0:0]       m_axis_tuser,   // ok[0]
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [8:0]  cfg_data
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_SWAP = 2'd2;

  logic [1:0]                   state;
  logic [1:0]                   state_next;
  logic [ins_pkg::KIND_W-1:0]   kind;
  logic [ins_pkg::NODE_W-1:0]   node;
  logic [ins_pkg::SLOT_W-1:0]   position;
  logic [ins_pkg::SIZE_W-1:0]   count;
  logic [ins_pkg::SIZE_W-1:0]   count_next;
  logic [ins_pkg::SIZE_W-1:0]   capacity;
  logic [ins_pkg::SLOT_COUNT-1:0] is_member;
  logic                         member_set;
  logic                         member_clr;

  logic                         out_valid;
  logic                         out_ok;
  logic [ins_pkg::NODE_W-1:0]   out_node;
  logic [ins_pkg::SIZE_W-1:0]   out_size;

  ins_pkg::store_req_t          req;
  logic [ins_pkg::NODE_W-1:0]   list_rdata;
  logic [ins_pkg::SLOT_W-1:0]   slot_rdata;

  logic in_accept;
  logic go;
  logic in_range;
  logic present;
  logic pos_ok;
  logic res_ok;
  logic [ins_pkg::NODE_W-1:0] res_node;

  assign s_axis_tready = (state == S_IDLE) && !rst;
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign cfg_ready     = !rst;
  assign go            = !out_valid || m_axis_tready;

  assign in_range = (32'(node) < 32'(NODE_COUNT));
  assign present  = in_range && is_member[node];
  assign pos_ok   = ({1'b0, position} < count);

  ins_store u_store (
    .clk        (clk),
    .req        (req),
    .list_rdata (list_rdata),
    .slot_rdata (slot_rdata)
  );

  always_comb begin
    req            = '0;
    req.rd_en      = in_accept;
    req.slot_raddr = s_axis_tdata[7:0];
    // Remove reads the last member; reposition and read read the given slot.
    if (s_axis_tuser == ins_pkg::KIND_REMOVE) begin
      req.list_raddr = 8'(count - 9'd1);
    end else begin
      req.list_raddr = s_axis_tdata[15:8];
    end

    state_next = state;
    count_next = count;
    member_set = 1'b0;
    member_clr = 1'b0;
    res_ok     = 1'b0;
    res_node   = '0;

    unique case (state)
      S_IDLE: begin
        if (in_accept) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (go) begin
          state_next = S_IDLE;
          unique case (kind)
            ins_pkg::KIND_ADD: begin
              res_ok = (count < capacity) && (count < 9'd256) && in_range &&
                       !is_member[node];
              if (res_ok) begin
                req.list_we    = 1'b1;
                req.list_waddr = count[7:0];
                req.list_wdata = node;
                req.slot_we    = 1'b1;
                req.slot_waddr = node;
                req.slot_wdata = count[7:0];
                member_set     = 1'b1;
                count_next     = count + 9'd1;
              end
            end
            ins_pkg::KIND_REMOVE: begin
              res_ok = present;
              if (res_ok) begin
                // The last member moves into the freed slot.
                req.list_we    = 1'b1;
                req.list_waddr = slot_rdata;
                req.list_wdata = list_rdata;
                req.slot_we    = 1'b1;
                req.slot_waddr = list_rdata;
                req.slot_wdata = slot_rdata;
                member_clr     = 1'b1;
                count_next     = count - 9'd1;
              end
            end
            ins_pkg::KIND_REPOS: begin
              res_ok = present && pos_ok;
              if (res_ok) begin
                req.list_we    = 1'b1;
                req.list_waddr = position;
                req.list_wdata = node;
                req.slot_we    = 1'b1;
                req.slot_waddr = node;
                req.slot_wdata = position;
                state_next     = S_SWAP;
              end
            end
            ins_pkg::KIND_READ: begin
              res_ok = pos_ok;
              if (res_ok) begin
                res_node = list_rdata;
              end
            end
            default: begin
              res_ok = 1'b0;
            end
          endcase
        end
      end
      S_SWAP: begin
        // The displaced member takes the old slot of the moved node.
        req.list_we    = 1'b1;
        req.list_waddr = slot_rdata;
        req.list_wdata = list_rdata;
        req.slot_we    = 1'b1;
        req.slot_waddr = list_rdata;
        req.slot_wdata = slot_rdata;
        state_next     = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      kind     <= s_axis_tuser;
      node     <= s_axis_tdata[7:0];
      position <= s_axis_tdata[15:8];
    end
    if (state == S_EXEC && go) begin
      out_ok   <= res_ok;
      out_node <= res_node;
      out_size <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      capacity  <= 9'd256;
      is_member <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (cfg_valid && cfg_ready) begin
        capacity <= cfg_data;
      end
      if (member_set) begin
        is_member[node] <= 1'b1;
      end
      if (member_clr) begin
        is_member[node] <= 1'b0;
      end
      if (state == S_EXEC && go) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {7'd0, out_size, out_node};
  assign m_axis_tuser  = out_ok;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= 9'd256)
    else $error("member count above the slot count");

  a_swap_after_exec: assert property (@(posedge clk) disable iff (rst)
    (state == S_SWAP) |-> ($past(state) == S_EXEC))
    else $error("swap cycle not preceded by a decide cycle");

  a_result_from_exec: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $rose(out_valid)) |-> ($past(state) == S_EXEC))
    else $error("result loaded outside the decide cycle");

  a_count_only_in_exec: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && (count != $past(count))) |-> ($past(state) == S_EXEC))
    else $error("member count changed outside the decide cycle");

  a_size_matches: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $rose(out_valid)) |-> (out_size == count))
    else $error("reported size differs from the member count");

endmodule

`default_nettype wire

/* dv/tb_indexed_node_set_unit.sv */
module tb_indexed_node_set_unit;

  localparam int CYCLE_LIMIT   = 600000;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 300;

  typedef struct packed {
    logic                       ok;
    logic [ins_pkg::NODE_W-1:0] node_at;
    logic [ins_pkg::SIZE_W-1:0] size;
  } set_result_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [15:0]       s_axis_tdata = '0;   // node[7:0], position[15:8]
  logic [1:0]        s_axis_tuser = '0;   // kind[1:0]
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [23:0]       m_axis_tdata;        // node_at_position[7:0], set_size[16:8]
  logic [0:0]        m_axis_tuser;        // ok[0]
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [8:0]        cfg_data = '0;

  // Mirror of the set: dense roster, slot of each node, membership bits.
  logic [ins_pkg::NODE_W-1:0] roster [ins_pkg::SLOT_COUNT];
  logic [ins_pkg::SLOT_W-1:0] slot_index [ins_pkg::SLOT_COUNT];
  logic                       present [ins_pkg::SLOT_COUNT];
  logic [ins_pkg::SIZE_W-1:0] roster_len = '0;
  logic [ins_pkg::SIZE_W-1:0] capacity = 9'd256;

  set_result_t pending_results [$];
  int error_count = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  logic hold_request = 1'b0;
  logic hold_taken = 1'b0;
  int recv_hold = 0;

  indexed_node_set_unit dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    for (int i = 0; i < ins_pkg::SLOT_COUNT; i++) begin
      roster[i] = '0;
      slot_index[i] = '0;
      present[i] = 1'b0;
    end
  end

  function automatic set_result_t apply_set_op(input logic [ins_pkg::KIND_W-1:0] kind,
                                               input logic [ins_pkg::NODE_W-1:0] node,
                                               input logic [ins_pkg::SLOT_W-1:0] pos);
    set_result_t res;
    logic [ins_pkg::SLOT_W-1:0] slot;
    logic [ins_pkg::NODE_W-1:0] moved;
    res = '0;
    case (kind)
      ins_pkg::KIND_ADD: begin
        if (roster_len < capacity && roster_len < ins_pkg::SLOT_COUNT && !present[node]) begin
          roster[roster_len[ins_pkg::SLOT_W-1:0]] = node;
          slot_index[node] = roster_len[ins_pkg::SLOT_W-1:0];
          present[node] = 1'b1;
          roster_len = roster_len + 9'd1;
          res.ok = 1'b1;
        end
      end
      ins_pkg::KIND_REMOVE: begin
        if (present[node] && roster_len > 0) begin
          slot = slot_index[node];
          moved = roster[8'(roster_len - 9'd1)];
          roster[slot] = moved;
          slot_index[moved] = slot;
          present[node] = 1'b0;
          roster_len = roster_len - 9'd1;
          res.ok = 1'b1;
        end
      end
      ins_pkg::KIND_REPOS: begin
        if (present[node] && pos < roster_len) begin
          moved = roster[pos];
          slot = slot_index[node];
          roster[pos] = node;
          slot_index[node] = pos;
          roster[slot] = moved;
          slot_index[moved] = slot;
          res.ok = 1'b1;
        end
      end
      default: begin
        if (pos < roster_len) begin
          res.node_at = roster[pos];
          res.ok = 1'b1;
        end
      end
    endcase
    res.size = roster_len;
    return res;
  endfunction

  task automatic send_item(input logic [ins_pkg::KIND_W-1:0] kind,
                           input logic [ins_pkg::NODE_W-1:0] node,
                           input logic [ins_pkg::SLOT_W-1:0] pos);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {pos, node};
    s_axis_tuser <= kind;
    do @(posedge clk); while (!s_axis_tready);
    pending_results.push_back(apply_set_op(kind, node, pos));
  endtask

  task automatic wait_results_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [8:0] value);
    wait_results_drained();
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    capacity = value;
  endtask

  // Mostly well-formed operations on current members; a few fully random items.
  task automatic send_random_item(input int add_weight);
    logic [ins_pkg::KIND_W-1:0] kind;
    logic [ins_pkg::NODE_W-1:0] node;
    logic [ins_pkg::SLOT_W-1:0] pos;
    int len;
    len = roster_len;
    kind = 2'($urandom_range(3));
    node = 8'($urandom_range(255));
    pos = 8'($urandom_range(255));
    if ($urandom_range(99) >= 5) begin
      if ($urandom_range(99) < add_weight) begin
        kind = ins_pkg::KIND_ADD;
        if (present[node] && $urandom_range(3) != 0) begin
          for (int i = 1; i < ins_pkg::SLOT_COUNT; i++) begin
            if (!present[8'((node + i) % ins_pkg::SLOT_COUNT)]) begin
              node = 8'((node + i) % ins_pkg::SLOT_COUNT);
              break;
            end
          end
        end
      end else begin
        case ($urandom_range(2))
          0: kind = ins_pkg::KIND_REMOVE;
          1: kind = ins_pkg::KIND_REPOS;
          default: kind = ins_pkg::KIND_READ;
        endcase
        if (len > 0 && $urandom_range(9) != 0) begin
          node = roster[8'($urandom_range(len - 1))];
          pos = 8'($urandom_range(len - 1));
        end
      end
    end
    send_item(kind, node, pos);
  endtask

  task automatic test_directed();
    send_item(ins_pkg::KIND_READ, 8'd0, 8'd0);
    send_item(ins_pkg::KIND_REMOVE, 8'd0, 8'd0);
    send_item(ins_pkg::KIND_REPOS, 8'd0, 8'd0);
    send_item(ins_pkg::KIND_ADD, 8'd0, 8'd255);
    send_item(ins_pkg::KIND_ADD, 8'd255, 8'd0);
    send_item(ins_pkg::KIND_ADD, 8'd0, 8'd0);
    send_item(ins_pkg::KIND_ADD, 8'd170, 8'd85);
    send_item(ins_pkg::KIND_ADD, 8'd85, 8'd170);
    send_item(ins_pkg::KIND_READ, 8'd255, 8'd0);
    send_item(ins_pkg::KIND_READ, 8'd0, 8'd3);
    send_item(ins_pkg::KIND_READ, 8'd0, 8'd255);
    send_item(ins_pkg::KIND_REPOS, 8'd255, 8'd0);
    // Node 0 now sits in slot 1; moving it there changes nothing.
    send_item(ins_pkg::KIND_REPOS, 8'd0, 8'd1);
    send_item(ins_pkg::KIND_REPOS, 8'd85, 8'd200);
    send_item(ins_pkg::KIND_REMOVE, 8'd255, 8'd0);
    send_item(ins_pkg::KIND_REMOVE, 8'd170, 8'd0);
    send_item(ins_pkg::KIND_READ, 8'd0, 8'd1);
    write_capacity(9'd1);
    send_item(ins_pkg::KIND_ADD, 8'd7, 8'd0);
    write_capacity(9'd0);
    send_item(ins_pkg::KIND_ADD, 8'd9, 8'd0);
    send_item(ins_pkg::KIND_REMOVE, 8'd85, 8'd0);
    send_item(ins_pkg::KIND_REMOVE, 8'd0, 8'd0);
    send_item(ins_pkg::KIND_ADD, 8'd9, 8'd0);
    write_capacity(9'd1);
    send_item(ins_pkg::KIND_ADD, 8'd9, 8'd0);
    send_item(ins_pkg::KIND_ADD, 8'd10, 8'd0);
    wait_results_drained();
  endtask

  task automatic test_random_phase(input int send_pct, input int recv_pct,
                                   input logic [8:0] cap, input int add_weight,
                                   input int count);
    write_capacity(cap);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (count) send_random_item(add_weight);
    wait_results_drained();
  endtask

  // The receiver stops for a long stretch while items keep coming, so the
  // block has to stall its input side.
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 10;
    hold_request <= 1'b1;
    repeat (80) send_random_item(40);
    wait_results_drained();
  endtask

  // The receiver counts its own hold once the backpressure test asks for it.
  always @(posedge clk) begin
    if (hold_request && !hold_taken) begin
      hold_taken <= 1'b1;
      recv_hold <= HOLD_CYCLES - 1;
      m_axis_tready <= 1'b0;
    end else if (recv_hold > 0) begin
      m_axis_tready <= 1'b0;
      recv_hold <= recv_hold - 1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      error_count++;
    end
  endfunction

  always @(posedge clk) begin : result_check
    set_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none actual ok=%0d node=%0d size=%0d",
                 $time, m_axis_tuser[0], m_axis_tdata[7:0], m_axis_tdata[16:8]);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("ok", want.ok, m_axis_tuser[0]);
        check_field("node_at_position", want.node_at, m_axis_tdata[7:0]);
        check_field("set_size", want.size, m_axis_tdata[16:8]);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("indexed_node_set_unit verification failed");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    // A capacity above 256 fills the whole set.
    test_random_phase(27, 76, 9'd511, 70, 650);
    // Capacity zero: adds are refused, while removes still shrink the set.
    test_random_phase(27, 76, 9'd0, 30, 100);
    test_random_phase(76, 27, 9'($urandom_range(2, 255)), 30, 600);
    test_random_phase(0, 0, 9'd256, 45, 600);
    test_backpressure();
    if (error_count == 0) begin
      $display("indexed_node_set_unit verification clean");
    end else begin
      $display("indexed_node_set_unit verification failed");
    end
    $finish;
  end

endmodule
